// ----- rtl/core/sorted_key_value_map_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted key/value map assertion macros
// Shared property wrappers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_MAP_MACROS_SVH
`define SORTED_KEY_VALUE_MAP_MACROS_SVH

// same-cycle implication
`define SKVM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skvm: same-cycle check failed");

// next-cycle implication
`define SKVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skvm: next-cycle check failed");

`endif

// ----- rtl/core/skvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value map package
// Sizes and status codes shared by the map's RTL.
// ----------------------------------------------------------------------------
package skvm_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int ENTRY_W  = KEY_W + VAL_W;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

endpackage

// ----- rtl/core/skvm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sorted_key_value_map.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value map
// Fixed-capacity table of 64-bit key/value pairs kept in ascending key order,
// searched by binary search over a single RAM.
// ----------------------------------------------------------------------------
// Usage: one request on the slave stream; tuser = command (0 insert, 1 find),
// tdata = search_key then new_value. One result on the master stream per
// request; tuser = status (0 ok, 1 not found, 2 full), tdata = found_value.
// tready stays low from the time a request is taken until it is done.
// The binary search takes at most log2(CAPACITY)+1 probes, each a RAM read
// (S_PROBE) and then a key compare (S_CHECK). A new insert moves every
// entry at or above its slot up one place through the RAM's single read and
// write ports, one read (S_SHIFT_RD) then one write (S_SHIFT_WR) per moved
// entry, and then writes the new pair into the freed slot (S_PLACE).
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the block only when a second result is
// ready before the first one leaves.
// Reset empties the table at once (entry count to zero); no RAM clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_key_value_map_macros.svh"

module sorted_key_value_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,  // search_key, new_value
  input  logic                        s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // found_value
  output skvm_pkg::status_t           m_axis_tuser   // status
);
  import skvm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PROBE    = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_SHIFT_RD = 7'b0001000,
    S_SHIFT_WR = 7'b0010000,
    S_PLACE    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]   mid_q, mid_d;
  logic                cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [VAL_W-1:0]    val_q, val_d;
  status_t             res_st_q, res_st_d;
  logic [VAL_W-1:0]    res_val_q, res_val_d;
  logic                out_vld_q, out_vld_d;
  status_t             out_st_q, out_st_d;
  logic [VAL_W-1:0]    out_val_q, out_val_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]    mid_full;
  logic                key_eq;
  logic                key_lt;

  skvm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare unit: request key against the entry just read
  assign key_eq   = (key_q == ram_rdata[KEY_W-1:0]);
  assign key_lt   = (key_q <  ram_rdata[KEY_W-1:0]);
  assign mid_full = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    mid_d     = mid_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    val_d     = val_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    out_vld_d = out_vld_q;
    out_st_d  = out_st_q;
    out_val_d = out_val_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = mid_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d     = s_axis_tuser;
          key_d     = s_axis_tdata[KEY_W-1:0];
          val_d     = s_axis_tdata[ENTRY_W-1:KEY_W];
          lo_d      = '0;
          hi_d      = count_q;
          res_st_d  = ST_OK;
          res_val_d = '0;
          state_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d     = mid_full[ADDR_W-1:0];
          ram_raddr = mid_full[ADDR_W-1:0];
          state_d   = S_CHECK;
        end else if (cmd_q) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else if (count_q > lo_q) begin
          idx_d   = count_q;
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_CHECK: begin
        if (key_eq) begin
          if (cmd_q) begin
            res_val_d = ram_rdata[ENTRY_W-1:KEY_W];
          end
          state_d = S_DONE;
        end else begin
          if (key_lt) begin
            hi_d = {1'b0, mid_q};
          end else begin
            lo_d = {1'b0, mid_q} + CNT_W'(1);
          end
          state_d = S_PROBE;
        end
      end
      S_SHIFT_RD: begin
        idx_d     = idx_q - CNT_W'(1);
        ram_raddr = idx_d[ADDR_W-1:0];
        state_d   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // idx_q already points at the source entry; write it one place up
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(idx_q + CNT_W'(1));
        ram_wdata = ram_rdata;
        state_d   = (idx_q > lo_q) ? S_SHIFT_RD : S_PLACE;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[ADDR_W-1:0];
        ram_wdata = {val_q, key_q};
        count_d   = count_q + CNT_W'(1);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_st_d  = res_st_q;
          out_val_d = res_val_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    idx_q     <= idx_d;
    mid_q     <= mid_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_st_q;

  `SKVM_ASSERT_IMPLY(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY))
  `SKVM_ASSERT_NEXT(a_place_grows, state_q == S_PLACE, count_q == $past(count_q) + CNT_W'(1))
  `SKVM_ASSERT_IMPLY(a_window, state_q == S_PROBE || state_q == S_CHECK, lo_q <= hi_q)
  `SKVM_ASSERT_IMPLY(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_FULL)

endmodule
